// ===== sv/fmbs_pkg.sv =====
// package with constants, codes and state types of the fm-index backward search block
`default_nettype none
package fmbs_pkg;

  // store sizes
  localparam int unsigned TEXT_DEPTH  = 65536;
  localparam int unsigned MIN_OCC_GAP = 16;
  localparam int unsigned MIN_SA_GAP  = 16;
  localparam int unsigned MAX_WALK    = 4096;
  localparam int unsigned GAP_MAX     = 256;
  localparam int unsigned CK_DEPTH    = 4 * (TEXT_DEPTH / MIN_OCC_GAP + 1);
  localparam int unsigned SA_DEPTH    = TEXT_DEPTH / MIN_SA_GAP + 1;
  localparam int unsigned ROW_MAX     = 131071;

  localparam int unsigned BWT_AW = $clog2(TEXT_DEPTH);
  localparam int unsigned CK_AW  = $clog2(CK_DEPTH);
  localparam int unsigned SA_AW  = $clog2(SA_DEPTH);

  // divider: 18-bit dividend, 9-bit divisor
  localparam int unsigned DIV_W     = 18;
  localparam int unsigned DEN_W     = 9;
  localparam int unsigned DIV_STEPS = DIV_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned WALK_W    = $clog2(MAX_WALK + 1);

  // input modes
  localparam logic [2:0] MODE_LOAD_BWT = 3'd0;
  localparam logic [2:0] MODE_LOAD_CK  = 3'd1;
  localparam logic [2:0] MODE_LOAD_SA  = 3'd2;
  localparam logic [2:0] MODE_SEARCH   = 3'd3;
  localparam logic [2:0] MODE_LOCATE   = 3'd4;

  // symbols
  localparam logic [2:0] SYM_END = 3'd4;
  localparam logic [2:0] SYM_BAD = 3'd7;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_SYM  = 2'd1;
  localparam logic [1:0] ERR_CAP  = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_COUNT_A     = 3'd0;
  localparam logic [2:0] CFG_COUNT_C     = 3'd1;
  localparam logic [2:0] CFG_COUNT_G     = 3'd2;
  localparam logic [2:0] CFG_TEXT_LENGTH = 3'd3;
  localparam logic [2:0] CFG_OCC_GAP     = 3'd4;
  localparam logic [2:0] CFG_SA_GAP      = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DIV,
    S_CKRD,
    S_CKWAIT,
    S_SCAN,
    S_OCCEND,
    S_LOC,
    S_LOCSYM,
    S_LOCCHK,
    S_SAWAIT,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    PH_LO,
    PH_HI,
    PH_LF
  } phase_t;

endpackage
`default_nettype wire

// ===== sv/fm_index_backward_search.sv =====
// top level of the fm-index backward search and locate block
//
// channel  | dir | handshake              | payload
// ---------+-----+------------------------+-------------------------------------------
// s_axis   | in  | s_tvalid / s_tready    | tuser mode, tdata addr value symbol first
// m_axis   | out | m_tvalid / m_tready    | tuser kind, tdata range, position, error
// cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// load items write their store when taken. a search item with a valid symbol and a
// non-empty range takes two occ lookups, each one a run of the shared divider, a ck
// read and a scan of the bwt rows one at a time (up to occ_gap-1 rows). a locate item
// takes per lf step a divider run for the sample test plus one occ lookup. the shared
// restoring divider and the single bwt read port set the cost of each item.
// rst resets control state, the range and the configuration registers; the stores are undefined until loaded.
// input is taken only when the sequencer is idle; a finished result waits in the
// output register while the next item is taken.
`default_nettype none
module fm_index_backward_search
  import fmbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [2:0]  s_tuser,   // mode[2:0]
  input  wire logic [39:0] s_tdata,   // addr[15:0] value[32:16] symbol[35:33] first[36]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [0:0]       m_tuser,   // kind[0]
  output logic [55:0]      m_tdata,   // range_low[16:0] range_high[33:17] empty_res[34]
                                      // text_position[50:35] error[52:51]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  // input fields
  logic [2:0]  in_mode;
  logic [15:0] in_addr;
  logic [16:0] in_value;
  logic [2:0]  in_symbol;
  logic        in_first;
  logic        in_acc;

  assign in_mode   = s_tuser;
  assign in_addr   = s_tdata[15:0];
  assign in_value  = s_tdata[32:16];
  assign in_symbol = s_tdata[35:33];
  assign in_first  = s_tdata[36];

  // configuration registers
  logic [16:0] count_a, count_c, count_g, text_length;
  logic [8:0]  occ_gap, sa_gap;
  logic [8:0]  cfg_gap;

  assign cfg_ready = 1'b1;
  assign cfg_gap   = cfg_data[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a     <= '0;
      count_c     <= '0;
      count_g     <= '0;
      text_length <= 17'd1;
      occ_gap     <= 9'd64;
      sa_gap      <= 9'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COUNT_A: count_a <= cfg_data;
        CFG_COUNT_C: count_c <= cfg_data;
        CFG_COUNT_G: count_g <= cfg_data;
        CFG_TEXT_LENGTH: begin
          if (cfg_data == '0) text_length <= 17'd1;
          else if (cfg_data > 17'(TEXT_DEPTH)) text_length <= 17'(TEXT_DEPTH);
          else text_length <= cfg_data;
        end
        CFG_OCC_GAP: begin
          if (cfg_gap < 9'(MIN_OCC_GAP)) occ_gap <= 9'(MIN_OCC_GAP);
          else if (cfg_gap > 9'(GAP_MAX)) occ_gap <= 9'(GAP_MAX);
          else occ_gap <= cfg_gap;
        end
        CFG_SA_GAP: begin
          if (cfg_gap < 9'(MIN_SA_GAP)) sa_gap <= 9'(MIN_SA_GAP);
          else if (cfg_gap > 9'(GAP_MAX)) sa_gap <= 9'(GAP_MAX);
          else sa_gap <= cfg_gap;
        end
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  state_t state, state_next;
  phase_t phase;

  logic [2:0]        mode_r;
  logic [2:0]        sym_r;     // search symbol
  logic [1:0]        s_r;       // symbol for the running occ lookup
  logic [2:0]        ch;        // bwt symbol at the locate row
  logic [16:0]       lo, hi, new_lo, row;
  logic [17:0]       pos, scan_i, acc;
  logic [1:0]        err_r;
  logic [15:0]       pos_out;
  logic [WALK_W-1:0] cnt;
  logic              ck_ok, sa_ok, pend, pend_ok, div_sa;

  // shared restoring divider
  logic [DIV_W-1:0]  dq;        // dividend shifting out, quotient shifting in
  logic [DEN_W-1:0]  rr;        // partial remainder
  logic [DEN_W-1:0]  den;
  logic [DCNT_W-1:0] dcnt;
  logic [DEN_W:0]    dtrial;
  logic              dfit;
  logic              div_last;

  assign dtrial   = {rr, dq[DIV_W-1]};
  assign dfit     = dtrial >= {1'b0, den};
  assign div_last = dcnt == DCNT_W'(DIV_STEPS - 1);

  // memories
  logic [2:0]  bwt_mem [TEXT_DEPTH];
  logic [16:0] ck_mem  [CK_DEPTH];
  logic [15:0] sa_mem  [SA_DEPTH];
  logic [2:0]  bwt_q;
  logic [16:0] ck_q;
  logic [15:0] sa_q;
  logic [BWT_AW-1:0] bwt_raddr;
  logic [19:0] ck_idx;

  assign in_acc    = s_tvalid && s_tready;
  assign bwt_raddr = (state == S_SCAN) ? scan_i[BWT_AW-1:0] : row[BWT_AW-1:0];
  assign ck_idx    = {dq, 2'b00} + 20'(s_r);

  always_ff @(posedge clk) begin
    if (in_acc && in_mode == MODE_LOAD_BWT) bwt_mem[in_addr] <= in_symbol;
    bwt_q <= bwt_mem[bwt_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_mode == MODE_LOAD_CK && 32'(in_addr) < CK_DEPTH)
      ck_mem[in_addr[CK_AW-1:0]] <= in_value;
    ck_q <= ck_mem[ck_idx[CK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_mode == MODE_LOAD_SA && 32'(in_addr) < SA_DEPTH)
      sa_mem[in_addr[SA_AW-1:0]] <= in_value[15:0];
    sa_q <= sa_mem[dq[SA_AW-1:0]];
  end

  // c(s) and the saturated lf row
  logic [18:0] base;
  logic [19:0] lf_sum;
  logic [16:0] lf_sat;
  logic        scan_done;

  always_comb begin
    base = '0;
    if (s_r >= 2'd1) base = base + 19'(count_a);
    if (s_r >= 2'd2) base = base + 19'(count_c);
    if (s_r >= 2'd3) base = base + 19'(count_g);
  end

  assign lf_sum    = 20'(base) + 20'(acc) + ((phase == PH_HI) ? 20'd0 : 20'd1);
  assign lf_sat    = (lf_sum > 20'(ROW_MAX)) ? 17'(ROW_MAX) : lf_sum[16:0];
  assign scan_done = (scan_i >= pos) && !pend;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && in_mode == MODE_SEARCH) state_next = S_SEARCH;
        else if (in_acc && in_mode == MODE_LOCATE) state_next = S_LOC;
      end
      S_SEARCH: begin
        if (sym_r >= SYM_END || lo > hi) state_next = S_RESULT;
        else state_next = S_DIV;
      end
      S_DIV: begin
        if (div_last) state_next = div_sa ? S_LOCCHK : S_CKRD;
      end
      S_CKRD:   state_next = S_CKWAIT;
      S_CKWAIT: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_done) state_next = S_OCCEND;
      end
      S_OCCEND: begin
        case (phase)
          PH_LO:   state_next = S_DIV;
          PH_HI:   state_next = S_RESULT;
          default: state_next = S_LOC;
        endcase
      end
      S_LOC:    state_next = S_LOCSYM;
      S_LOCSYM: state_next = S_DIV;
      S_LOCCHK: begin
        if (rr == '0) state_next = S_SAWAIT;
        else if (ch >= SYM_END) state_next = S_RESULT;
        else if (cnt >= WALK_W'(MAX_WALK)) state_next = S_RESULT;
        else state_next = S_DIV;
      end
      S_SAWAIT: state_next = S_RESULT;
      S_RESULT: begin
        if (!m_tvalid) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
      hi <= '0;
    end else begin
      if (state == S_IDLE && in_acc && in_mode == MODE_SEARCH && in_first) begin
        lo <= '0;
        hi <= text_length - 17'd1;
      end else if (state == S_OCCEND && phase == PH_HI) begin
        lo <= new_lo;
        hi <= lf_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          mode_r  <= in_mode;
          sym_r   <= in_symbol;
          row     <= {1'b0, in_addr};
          cnt     <= '0;
          err_r   <= ERR_NONE;
          pos_out <= '0;
        end
      end
      S_SEARCH: begin
        err_r  <= (sym_r >= SYM_END) ? ERR_SYM : ERR_NONE;
        s_r    <= sym_r[1:0];
        pos    <= {1'b0, lo};
        dq     <= {1'b0, lo};
        rr     <= '0;
        dcnt   <= '0;
        den    <= occ_gap;
        div_sa <= 1'b0;
        phase  <= PH_LO;
      end
      S_DIV: begin
        rr   <= dfit ? DEN_W'(dtrial - {1'b0, den}) : dtrial[DEN_W-1:0];
        dq   <= {dq[DIV_W-2:0], dfit};
        dcnt <= dcnt + DCNT_W'(1);
      end
      S_CKRD: begin
        ck_ok  <= ck_idx < 20'(CK_DEPTH);
        scan_i <= pos - 18'(rr);
      end
      S_CKWAIT: begin
        acc  <= ck_ok ? 18'(ck_q) : '0;
        pend <= 1'b0;
      end
      S_SCAN: begin
        if (scan_i < pos) begin
          pend    <= 1'b1;
          pend_ok <= scan_i < 18'(TEXT_DEPTH);
          scan_i  <= scan_i + 18'd1;
        end else begin
          pend <= 1'b0;
        end
        if (pend && pend_ok && bwt_q == {1'b0, s_r}) acc <= acc + 18'd1;
      end
      S_OCCEND: begin
        case (phase)
          PH_LO: begin
            new_lo <= lf_sat;
            pos    <= 18'(hi) + 18'd1;
            dq     <= 18'(hi) + 18'd1;
            rr     <= '0;
            dcnt   <= '0;
            phase  <= PH_HI;
          end
          PH_HI: ;
          default: begin
            row <= lf_sat;
            cnt <= cnt + WALK_W'(1);
          end
        endcase
      end
      S_LOCSYM: begin
        ch     <= (row < 17'(TEXT_DEPTH)) ? bwt_q : SYM_BAD;
        dq     <= 18'(row);
        rr     <= '0;
        dcnt   <= '0;
        den    <= sa_gap;
        div_sa <= 1'b1;
      end
      S_LOCCHK: begin
        if (rr == '0) begin
          sa_ok <= dq < 18'(SA_DEPTH);
        end else if (ch == SYM_END) begin
          pos_out <= 16'(cnt);
        end else if (ch > SYM_END) begin
          err_r <= ERR_SYM;
        end else if (cnt >= WALK_W'(MAX_WALK)) begin
          err_r <= ERR_CAP;
        end else begin
          s_r    <= ch[1:0];
          pos    <= 18'(row);
          dq     <= 18'(row);
          rr     <= '0;
          dcnt   <= '0;
          den    <= occ_gap;
          div_sa <= 1'b0;
          phase  <= PH_LF;
        end
      end
      S_SAWAIT: begin
        pos_out <= (sa_ok ? sa_q : 16'd0) + 16'(cnt);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESULT && !m_tvalid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && !m_tvalid) begin
      if (mode_r == MODE_LOCATE) begin
        m_tuser <= 1'b1;
        m_tdata <= {3'b000, err_r, (err_r == ERR_NONE) ? pos_out : 16'd0, 35'd0};
      end else begin
        m_tuser <= 1'b0;
        m_tdata <= {3'b000, err_r, 16'd0, lo > hi, hi, lo};
      end
    end
  end

  // a search result never carries the walk cap error
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == 1'b0) |-> m_tdata[52:51] != ERR_CAP)
    else $error("search result with walk cap error");

  // a locate result carries no range
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == 1'b1) |-> m_tdata[34:0] == '0)
    else $error("locate result with range fields set");

  // a locate error carries no position
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == 1'b1 && m_tdata[52:51] != ERR_NONE) |-> m_tdata[50:35] == '0)
    else $error("locate error with a position");

  // the divider never runs past its step count
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> dcnt <= DCNT_W'(DIV_STEPS - 1))
    else $error("divider step count overrun");

endmodule
`default_nettype wire
